// ===== design/cis_pkg.sv =====
package cis_pkg;

	localparam int unsigned MaxPairs = 65536;
	localparam int unsigned CountCap = (MaxPairs < 131071) ? MaxPairs : 131071;
	localparam int unsigned CntW = 17;
	localparam int unsigned CoordW = 20;
	localparam int unsigned DiffW = 21;
	localparam int unsigned SqW = 42;
	localparam int unsigned Dist2W = 44;
	localparam int unsigned SumW = 54;
	localparam int unsigned DistW = 19;
	localparam int unsigned IdxW = 16;
	localparam int unsigned FitW = 17;
	localparam int unsigned DivNumW = 33;
	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW = 2;

	typedef struct packed {
		logic signed [CoordW-1:0] src_x;
		logic signed [CoordW-1:0] src_y;
		logic signed [CoordW-1:0] src_z;
		logic signed [CoordW-1:0] dst_x;
		logic signed [CoordW-1:0] dst_y;
		logic signed [CoordW-1:0] dst_z;
		logic [IdxW-1:0] src_index;
		logic [IdxW-1:0] dst_index;
		logic last_pair;
	} pair_req_t;

	typedef struct packed {
		logic [IdxW-1:0] pair_src;
		logic [IdxW-1:0] pair_dst;
		logic inlier;
		logic final_res;
		logic [CntW-1:0] inlier_total;
		logic [CntW-1:0] pair_total;
		logic [FitW-1:0] fitness;
		logic [DistW-1:0] rmse;
	} score_res_t;

	// front to back queue entry
	typedef struct packed {
		logic [IdxW-1:0] pair_src;
		logic [IdxW-1:0] pair_dst;
		logic inlier;
		logic last;
		logic [Dist2W-1:0] dist2;
	} cls_ent_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_SQRT_DIV,
		BK_SQRT,
		BK_OUT
	} bk_state_t;

endpackage

// ===== design/cis_if.sv =====
interface cis_req_if;
	import cis_pkg::*;
	logic valid;
	logic ready;
	pair_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cis_res_if;
	import cis_pkg::*;
	logic valid;
	logic ready;
	score_res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/cis_front.sv =====
module cis_front import cis_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic [DistW-1:0] max_distance,
	cis_req_if.sink req,
	output logic ent_valid,
	input  logic ent_ready,
	output cls_ent_t ent
);
	logic v_s1, v_s2;
	logic [IdxW-1:0] si_s1, di_s1, si_s2, di_s2;
	logic last_s1, last_s2;
	logic [SqW-1:0] sx_s1, sy_s1, sz_s1;
	logic [2*DistW-1:0] lim_s1;
	logic [Dist2W-1:0] d2_s2;
	logic in_s2;
	logic [DiffW-1:0] dx, dy, dz;
	logic [DiffW-1:0] ax, ay, az;
	logic adv1, adv2;
	logic [Dist2W-1:0] sum;

	assign dx = DiffW'($signed(req.data.src_x) - $signed(req.data.dst_x));
	assign dy = DiffW'($signed(req.data.src_y) - $signed(req.data.dst_y));
	assign dz = DiffW'($signed(req.data.src_z) - $signed(req.data.dst_z));
	assign ax = dx[DiffW-1] ? DiffW'(-dx) : dx;
	assign ay = dy[DiffW-1] ? DiffW'(-dy) : dy;
	assign az = dz[DiffW-1] ? DiffW'(-dz) : dz;
	assign sum = Dist2W'(sx_s1) + Dist2W'(sy_s1) + Dist2W'(sz_s1);

	assign adv2 = !v_s2 || ent_ready;
	assign adv1 = !v_s1 || adv2;
	assign req.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= req.valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && req.valid) begin
			sx_s1 <= SqW'(ax * ax);
			sy_s1 <= SqW'(ay * ay);
			sz_s1 <= SqW'(az * az);
			lim_s1 <= max_distance * max_distance;
			si_s1 <= req.data.src_index;
			di_s1 <= req.data.dst_index;
			last_s1 <= req.data.last_pair;
		end
		if (adv2 && v_s1) begin
			d2_s2 <= sum;
			in_s2 <= sum < Dist2W'(lim_s1);
			si_s2 <= si_s1;
			di_s2 <= di_s1;
			last_s2 <= last_s1;
		end
	end

	assign ent_valid = v_s2;
	assign ent = '{pair_src: si_s2, pair_dst: di_s2, inlier: in_s2, last: last_s2,
		dist2: d2_s2};
endmodule

// ===== design/cis_queue.sv =====
module cis_queue import cis_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cls_ent_t in_ent,
	output logic out_valid,
	input  logic out_ready,
	output cls_ent_t out_ent
);
	cls_ent_t mem_q [QDepth];
	logic [QPtrW-1:0] wp_q, rp_q;
	logic [QPtrW:0] cnt_q;
	logic wr, rd;

	assign in_ready = cnt_q != (QPtrW+1)'(QDepth);
	assign out_valid = cnt_q != '0;
	assign out_ent = mem_q[rp_q];
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPtrW+1)'(wr) - (QPtrW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_ent;
	end
endmodule

// ===== design/cis_back.sv =====
module cis_back import cis_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic ent_valid,
	output logic ent_ready,
	input  cls_ent_t ent,
	cis_res_if.source res
);
	bk_state_t st_q, st_d;
	logic [CntW-1:0] icnt_q, pcnt_q;
	logic [SumW-1:0] esum_q;
	logic [CntW-1:0] icnt_n, pcnt_n;
	logic [SumW-1:0] esum_n;
	logic [SumW:0] esum_add;
	logic take;
	score_res_t res_q;
	logic rv_q;
	// shared restoring divider
	logic [SumW-1:0] dq_q;
	logic [CntW:0] drem_q;
	logic [CntW-1:0] dden_q;
	logic [5:0] dcnt_q;
	logic [CntW+1:0] dtry;
	// sqrt
	logic [SumW-1:0] sv_q, sres_q, sbit_q;
	logic [SumW-1:0] ssum;

	assign take = ent_valid && (st_q == BK_IDLE) && (!rv_q || res.ready);
	assign ent_ready = take;
	assign res.valid = rv_q;
	assign res.data = res_q;

	always_comb begin
		icnt_n = icnt_q;
		pcnt_n = pcnt_q;
		esum_n = esum_q;
		esum_add = (SumW+1)'(esum_q) + (SumW+1)'(ent.dist2);
		if (pcnt_q < CntW'(CountCap)) begin
			pcnt_n = pcnt_q + 1'b1;
			if (ent.inlier) begin
				icnt_n = icnt_q + 1'b1;
				esum_n = esum_add[SumW] ? '1 : esum_add[SumW-1:0];
			end
		end
	end

	assign dtry = {drem_q, dq_q[SumW-1]} - (CntW+2)'(dden_q);
	assign ssum = sres_q + sbit_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: if (take && ent.last) st_d = BK_DIV;
			BK_DIV: if (dcnt_q == '0) st_d = (icnt_q == '0) ? BK_OUT : BK_SQRT_DIV;
			BK_SQRT_DIV: if (dcnt_q == '0) st_d = BK_SQRT;
			BK_SQRT: if (sbit_q == '0) st_d = BK_OUT;
			BK_OUT: if (!rv_q || res.ready) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			icnt_q <= '0;
			pcnt_q <= '0;
			esum_q <= '0;
			rv_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == BK_OUT && (!rv_q || res.ready)) begin
				rv_q <= 1'b1;
				icnt_q <= '0;
				pcnt_q <= '0;
				esum_q <= '0;
			end else begin
				if (take) begin
					icnt_q <= icnt_n;
					pcnt_q <= pcnt_n;
					esum_q <= esum_n;
				end
				if (take && !ent.last) rv_q <= 1'b1;
				else if (rv_q && res.ready) rv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= '{pair_src: ent.pair_src, pair_dst: ent.pair_dst, inlier: ent.inlier,
				final_res: ent.last, default: '0};
			dq_q <= SumW'({icnt_n, 16'h0}) << (SumW - DivNumW);
			drem_q <= '0;
			dden_q <= pcnt_n;
			dcnt_q <= 6'(DivNumW - 1);
		end
		unique case (st_q)
			BK_DIV: begin
				if (dcnt_q == '0) begin
					res_q.fitness <= (dden_q == '0) ? '0 :
						FitW'(dtry[CntW+1] ? {dq_q[SumW-2:0], 1'b0} : {dq_q[SumW-2:0], 1'b1});
					res_q.inlier_total <= icnt_q;
					res_q.pair_total <= pcnt_q;
					dq_q <= esum_q;
					drem_q <= '0;
					dden_q <= icnt_q;
					dcnt_q <= 6'(SumW - 1);
				end else begin
					if (dtry[CntW+1]) begin
						drem_q <= {drem_q[CntW-1:0], dq_q[SumW-1]};
						dq_q <= {dq_q[SumW-2:0], 1'b0};
					end else begin
						drem_q <= dtry[CntW:0];
						dq_q <= {dq_q[SumW-2:0], 1'b1};
					end
					dcnt_q <= dcnt_q - 1'b1;
				end
			end
			BK_SQRT_DIV: begin
				if (dcnt_q == '0) begin
					sv_q <= dtry[CntW+1] ? {dq_q[SumW-2:0], 1'b0} : {dq_q[SumW-2:0], 1'b1};
					sres_q <= '0;
					sbit_q <= SumW'(1) << (SumW - 2);
				end else begin
					if (dtry[CntW+1]) begin
						drem_q <= {drem_q[CntW-1:0], dq_q[SumW-1]};
						dq_q <= {dq_q[SumW-2:0], 1'b0};
					end else begin
						drem_q <= dtry[CntW:0];
						dq_q <= {dq_q[SumW-2:0], 1'b1};
					end
					dcnt_q <= dcnt_q - 1'b1;
				end
			end
			BK_SQRT: begin
				if (sv_q >= ssum) begin
					sv_q <= sv_q - ssum;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else sres_q <= sres_q >> 1;
				sbit_q <= sbit_q >> 2;
				if (sbit_q == '0) res_q.rmse <= DistW'(sres_q);
			end
			default: ;
		endcase
	end
endmodule

// ===== design/correspondence_inlier_scorer_core.sv =====
// Pairs go through a two-stage front (squares, then sum and limit compare) into a
// four-entry queue and are scored by the back one a cycle while it is idle and its
// result is taken, so a set streams at one pair per clock. The last pair of a set
// holds the back for a restoring divide for fitness, then, when the set has inliers,
// a divide for the mean squared inlier error and its root; the result is loaded last.
module correspondence_inlier_scorer_core import cis_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [DistW-1:0] cfg_wdata,
	cis_req_if.sink req,
	cis_res_if.source res
);
	logic [DistW-1:0] max_distance_q;
	logic fv, fr, bv, br;
	cls_ent_t fe, be;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_distance_q <= '0;
		else if (cfg_we) max_distance_q <= cfg_wdata;
	end

	cis_front u_front (.clk, .arst_n, .max_distance(max_distance_q), .req,
		.ent_valid(fv), .ent_ready(fr), .ent(fe));
	cis_queue u_queue (.clk, .arst_n, .in_valid(fv), .in_ready(fr), .in_ent(fe),
		.out_valid(bv), .out_ready(br), .out_ent(be));
	cis_back u_back (.clk, .arst_n, .ent_valid(bv), .ent_ready(br), .ent(be), .res);
endmodule
